FILE: design/tmbf_pkg.sv
package tmbf_pkg;

    localparam int MEM_BYTES        = 8192;
    localparam int MEM_AW           = $clog2(MEM_BYTES);
    localparam int MAP_TILES_ACROSS = 32;
    localparam int MAP_IDX_W        = $clog2(MAP_TILES_ACROSS);

    localparam logic [8:0] SCREEN_WIDTH  = 9'd160;
    localparam logic [8:0] SCREEN_HEIGHT = 9'd144;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_BG_ENABLE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_SELECT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_SELECT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_X    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_Y    = 3'd4;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    typedef struct packed {
        logic              is_write;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
        logic [2:0]        line;
        logic [2:0]        col_bit;
        logic              en;
        logic              dsel;
        logic [7:0]        x;
        logic [7:0]        y;
    } q_entry_t;

endpackage

FILE: design/tmbf_pix_in_if.sv
interface tmbf_pix_in_if;
    import tmbf_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_data;
    logic [7:0]        pixel_x;
    logic [7:0]        pixel_y;

    modport source (output valid, func, mem_addr, mem_data, pixel_x, pixel_y, input ready);
    modport sink (input valid, func, mem_addr, mem_data, pixel_x, pixel_y, output ready);
endinterface

FILE: design/tmbf_pix_out_if.sv
interface tmbf_pix_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] color_index;
    logic [7:0] out_x;
    logic [7:0] out_y;

    modport source (output valid, color_index, out_x, out_y, input ready);
    modport sink (input valid, color_index, out_x, out_y, output ready);
endinterface

FILE: design/tmbf_cfg_if.sv
interface tmbf_cfg_if;
    import tmbf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/tmbf_front.sv
module tmbf_front
    import tmbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tmbf_pix_in_if.sink pix_in,
    tmbf_cfg_if.sink    cfg,
    output logic       q_push,
    output q_entry_t   q_entry,
    input  logic       q_full
);

    logic       bg_enable_reg;
    logic       map_select_reg;
    logic       data_select_reg;
    logic [7:0] scroll_x_reg;
    logic [7:0] scroll_y_reg;

    logic [7:0] mx;
    logic [7:0] my;
    logic       on_screen;
    logic       is_write;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_enable_reg   <= 1'b0;
            map_select_reg  <= 1'b0;
            data_select_reg <= 1'b0;
            scroll_x_reg    <= 8'd0;
            scroll_y_reg    <= 8'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BG_ENABLE:   bg_enable_reg   <= cfg.data[0];
                CFG_MAP_SELECT:  map_select_reg  <= cfg.data[0];
                CFG_DATA_SELECT: data_select_reg <= cfg.data[0];
                CFG_SCROLL_X:    scroll_x_reg    <= cfg.data;
                CFG_SCROLL_Y:    scroll_y_reg    <= cfg.data;
                default:         ;
            endcase
        end
    end

    assign mx        = pix_in.pixel_x + scroll_x_reg;
    assign my        = pix_in.pixel_y + scroll_y_reg;
    assign is_write  = (pix_in.func == FUNC_WRITE);
    assign on_screen = ({1'b0, pix_in.pixel_x} < SCREEN_WIDTH)
                    && ({1'b0, pix_in.pixel_y} < SCREEN_HEIGHT);

    assign pix_in.ready = !q_full;

    // drop off-screen renders at the door
    assign q_push = pix_in.valid && !q_full && (is_write || on_screen);

    always_comb
    begin
        q_entry.is_write = is_write;
        q_entry.addr     = is_write ? pix_in.mem_addr
                         : {2'b11, map_select_reg, my[7:8-MAP_IDX_W], mx[7:8-MAP_IDX_W]};
        q_entry.data     = pix_in.mem_data;
        q_entry.line     = my[2:0];
        q_entry.col_bit  = mx[2:0];
        q_entry.en       = bg_enable_reg;
        q_entry.dsel     = data_select_reg;
        q_entry.x        = pix_in.pixel_x;
        q_entry.y        = pix_in.pixel_y;
    end

endmodule

FILE: design/tmbf_queue.sv
module tmbf_queue
    import tmbf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output q_entry_t head,
    output logic     head_valid
);

    q_entry_t              entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: design/tmbf_back.sv
module tmbf_back
    import tmbf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  q_entry_t q_head,
    input  logic     q_valid,
    output logic     q_pop,
    tmbf_pix_out_if.source pix_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TILE = 2'd1;
    localparam logic [1:0] S_LO   = 2'd2;
    localparam logic [1:0] S_HI   = 2'd3;

    logic [7:0]        vmem [MEM_BYTES];
    logic [7:0]        rdata_reg;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;

    logic [MEM_AW-1:0] tile_addr_reg;
    logic [MEM_AW-1:0] tile_addr_next;
    logic [7:0]        lo_reg;
    logic [2:0]        line_reg;
    logic [2:0]        bit_reg;
    logic              dsel_reg;
    logic [7:0]        x_reg;
    logic [7:0]        y_reg;

    logic              out_valid_reg;
    logic [1:0]        color_reg;
    logic [7:0]        out_x_reg;
    logic [7:0]        out_y_reg;

    logic              slot_free;
    logic              dispatch;
    logic              load_ctx;
    logic              mem_we;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_a;
    logic              out_load;
    logic [1:0]        color_next;
    logic [7:0]        out_x_next;
    logic [7:0]        out_y_next;

    assign slot_free = !out_valid_reg || pix_out.ready;

    always_comb
    begin
        state_next     = state_reg;
        tile_addr_next = tile_addr_reg;
        dispatch       = 1'b0;
        load_ctx       = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_a          = tile_addr_reg;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        color_next     = {rdata_reg[~bit_reg], lo_reg[~bit_reg]};
        out_x_next     = x_reg;
        out_y_next     = y_reg;

        case (state_reg)
            S_IDLE:
            begin
                dispatch = 1'b1;
            end
            S_TILE:
            begin
                tile_addr_next = {~dsel_reg & ~rdata_reg[7], rdata_reg, line_reg, 1'b0};
                mem_re         = 1'b1;
                mem_a          = tile_addr_next;
                state_next     = S_LO;
            end
            S_LO:
            begin
                mem_re     = 1'b1;
                mem_a      = {tile_addr_reg[MEM_AW-1:1], 1'b1};
                state_next = S_HI;
            end
            S_HI:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    dispatch   = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (dispatch && q_valid)
        begin
            if (q_head.is_write)
            begin
                mem_we = 1'b1;
                mem_a  = q_head.addr;
                q_pop  = 1'b1;
            end
            else if (!q_head.en)
            begin
                if (state_reg == S_IDLE && slot_free)
                begin
                    out_load   = 1'b1;
                    color_next = 2'd0;
                    out_x_next = q_head.x;
                    out_y_next = q_head.y;
                    q_pop      = 1'b1;
                end
            end
            else
            begin
                mem_re     = 1'b1;
                mem_a      = q_head.addr;
                load_ctx   = 1'b1;
                q_pop      = 1'b1;
                state_next = S_TILE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vmem[mem_a] <= q_head.data;
        end
        if (mem_re)
        begin
            rdata_reg <= vmem[mem_a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && !pix_out.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        tile_addr_reg <= tile_addr_next;
        if (state_reg == S_LO)
        begin
            lo_reg <= rdata_reg;
        end
        if (load_ctx)
        begin
            line_reg <= q_head.line;
            bit_reg  <= q_head.col_bit;
            dsel_reg <= q_head.dsel;
            x_reg    <= q_head.x;
            y_reg    <= q_head.y;
        end
        if (out_load)
        begin
            color_reg <= color_next;
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    assign pix_out.valid       = out_valid_reg;
    assign pix_out.color_index = color_reg;
    assign pix_out.out_x       = out_x_reg;
    assign pix_out.out_y       = out_y_reg;

`ifndef SYNTH
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("result overwrote an untaken result");

    a_write_off_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE || state_reg == S_HI))
        else $error("memory write during a tile fetch");

    a_fetch_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TILE) |=> (state_reg == S_LO) ##1 (state_reg == S_HI))
        else $error("tile fetch sequence broken");
`endif

endmodule

FILE: design/tile_map_background_fetch_unit.sv
// Background tile fetch with its own 8 KiB video memory on a single port. A write
// transfer (func 0) stores one byte through that port. A render transfer (func 1)
// of an on-screen pixel reads the map byte, then the low and high bitplane bytes
// through that port when the background is enabled; renders follow one another with
// no gap, and one every cycle with the background disabled, while the output takes
// each result. Off-screen renders are accepted and dropped without a result. A
// four-entry queue sits between input and memory, so input keeps flowing while a
// result waits at the output register, until the queue is full. Configuration
// writes take effect at once and are meant for an idle block. The video memory is
// not cleared after reset; read only bytes already written.
module tile_map_background_fetch_unit
    import tmbf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tmbf_pix_in_if.sink    pix_in,
    tmbf_pix_out_if.source pix_out,
    tmbf_cfg_if.sink       cfg
);

    logic     q_push;
    q_entry_t q_entry;
    logic     q_full;
    logic     q_pop;
    q_entry_t q_head;
    logic     q_valid;

    tmbf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .cfg     (cfg),
        .q_push  (q_push),
        .q_entry (q_entry),
        .q_full  (q_full)
    );

    tmbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_valid)
    );

    tmbf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .pix_out (pix_out)
    );

endmodule

FILE: tb/tile_map_background_fetch_unit_tb.sv
module tile_map_background_fetch_unit_tb;
    import tmbf_pkg::*;

    localparam int RAND_ITEMS  = 1950;
    localparam int SETTLE      = 16;
    localparam int STUCK_LIMIT = 5000;

    localparam logic [MEM_AW-1:0] MAP0_BASE   = 13'h1800;
    localparam logic [MEM_AW-1:0] MAP1_BASE   = 13'h1C00;
    localparam logic [MEM_AW-1:0] SIGNED_BASE = 13'h1000;

    typedef struct packed {
        logic [1:0] color;
        logic [7:0] x;
        logic [7:0] y;
    } pixel_t;

    typedef struct {
        logic              func;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
        logic [7:0]        px;
        logic [7:0]        py;
    } pix_req_t;

    typedef enum logic [1:0] {EXP_PREDICT, EXP_NO_RESULT, EXP_TYPED} exp_how_e;
    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e              kind;
        pix_req_t               req;
        exp_how_e               how;
        logic [1:0]             color;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
    } dir_row_t;

    logic clk;
    logic rst_n;

    tmbf_pix_in_if  pix_in_ch();
    tmbf_pix_out_if pix_out_ch();
    tmbf_cfg_if     cfg_ch();

    tile_map_background_fetch_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_ch),
        .pix_out (pix_out_ch),
        .cfg     (cfg_ch)
    );

    logic [7:0] vram [MEM_BYTES];
    bit         vram_set [MEM_BYTES];
    logic       bg_on;
    logic       map_hi;
    logic       tiles_unsigned;
    logic [7:0] scx;
    logic [7:0] scy;

    pixel_t   pixel_expq [$];
    dir_row_t dir_rows [$];
    int       err_cnt;
    int       stuck;
    bit       steady_phase;
    pixel_t   got_pix;
    pixel_t   want_pix;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [1:0] bg_color(logic [7:0] px, logic [7:0] py);
        logic [7:0]        mx;
        logic [7:0]        my;
        logic [7:0]        tile;
        logic [7:0]        lo;
        logic [7:0]        hi;
        logic [MEM_AW-1:0] map_addr;
        logic [MEM_AW-1:0] row_addr;
        logic [2:0]        bitpos;
        mx = px + scx;
        my = py + scy;
        map_addr = (map_hi ? MAP1_BASE : MAP0_BASE) + MEM_AW'({my[7:3], mx[7:3]});
        tile = vram[map_addr];
        if (tiles_unsigned || tile[7])
            row_addr = {1'b0, tile, 4'b0000};
        else
            row_addr = SIGNED_BASE + {1'b0, tile, 4'b0000};
        row_addr = row_addr + MEM_AW'({my[2:0], 1'b0});
        lo = vram[row_addr];
        hi = vram[row_addr + 13'd1];
        bitpos = 3'd7 - mx[2:0];
        return {hi[bitpos], lo[bitpos]};
    endfunction

    // first byte a render would read before it was ever written
    function automatic bit find_unwritten(input logic [7:0] px, input logic [7:0] py,
                                          output logic [MEM_AW-1:0] addr);
        logic [7:0]        mx;
        logic [7:0]        my;
        logic [7:0]        tile;
        logic [MEM_AW-1:0] map_addr;
        logic [MEM_AW-1:0] row_addr;
        addr = '0;
        if (!bg_on || {1'b0, px} >= SCREEN_WIDTH || {1'b0, py} >= SCREEN_HEIGHT)
            return 1'b0;
        mx = px + scx;
        my = py + scy;
        map_addr = (map_hi ? MAP1_BASE : MAP0_BASE) + MEM_AW'({my[7:3], mx[7:3]});
        if (!vram_set[map_addr])
        begin
            addr = map_addr;
            return 1'b1;
        end
        tile = vram[map_addr];
        if (tiles_unsigned || tile[7])
            row_addr = {1'b0, tile, 4'b0000};
        else
            row_addr = SIGNED_BASE + {1'b0, tile, 4'b0000};
        row_addr = row_addr + MEM_AW'({my[2:0], 1'b0});
        if (!vram_set[row_addr])
        begin
            addr = row_addr;
            return 1'b1;
        end
        if (!vram_set[row_addr + 13'd1])
        begin
            addr = row_addr + 13'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_val(logic [CFG_INDEX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] v;
        int                    r;
        v = CFG_DATA_W'($urandom);
        r = $urandom_range(0, 3);
        if (idx == CFG_BG_ENABLE)
        begin
            v[0] = ($urandom_range(0, 4) != 0);
            return v;
        end
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_cnt++;
    endtask

    task automatic send_pixel(input pix_req_t r, input exp_how_e how, input logic [1:0] color);
        int     gap;
        pixel_t e;
        gap = steady_phase ? 0 : idle_len();
        if (gap > 0)
        begin
            pix_in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_in_ch.valid    = 1'b1;
        pix_in_ch.func     = r.func;
        pix_in_ch.mem_addr = r.addr;
        pix_in_ch.mem_data = r.data;
        pix_in_ch.pixel_x  = r.px;
        pix_in_ch.pixel_y  = r.py;
        do
            @(posedge clk);
        while (!pix_in_ch.ready);
        if (r.func == FUNC_WRITE)
        begin
            vram[r.addr]     = r.data;
            vram_set[r.addr] = 1'b1;
        end
        else if ({1'b0, r.px} < SCREEN_WIDTH && {1'b0, r.py} < SCREEN_HEIGHT
                 && how != EXP_NO_RESULT)
        begin
            e.x = r.px;
            e.y = r.py;
            if (how == EXP_TYPED)
                e.color = color;
            else
                e.color = bg_on ? bg_color(r.px, r.py) : 2'd0;
            pixel_expq.push_back(e);
        end
        @(negedge clk);
    endtask

    // write every byte the render will read that is still unwritten
    task automatic prime_render(input logic [7:0] px, input logic [7:0] py);
        pix_req_t          w;
        logic [MEM_AW-1:0] a;
        while (find_unwritten(px, py, a))
        begin
            w.func = FUNC_WRITE;
            w.addr = a;
            w.data = 8'($urandom);
            w.px   = '0;
            w.py   = '0;
            send_pixel(w, EXP_PREDICT, 2'd0);
        end
    endtask

    task automatic pause_until_drained();
        pix_in_ch.valid = 1'b0;
        do
            @(negedge clk);
        while (pixel_expq.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        pause_until_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_BG_ENABLE:   bg_on = val[0];
            CFG_MAP_SELECT:  map_hi = val[0];
            CFG_DATA_SELECT: tiles_unsigned = val[0];
            CFG_SCROLL_X:    scx = val;
            CFG_SCROLL_Y:    scy = val;
            default:         ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic row_pix(input logic func, input logic [MEM_AW-1:0] addr,
                           input logic [7:0] data, input logic [7:0] px, input logic [7:0] py,
                           input exp_how_e how, input logic [1:0] color);
        dir_row_t row;
        row.kind     = ROW_PIXEL;
        row.req.func = func;
        row.req.addr = addr;
        row.req.data = data;
        row.req.px   = px;
        row.req.py   = py;
        row.how      = how;
        row.color    = color;
        row.reg_idx  = '0;
        row.reg_val  = '0;
        dir_rows.push_back(row);
    endtask

    task automatic row_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row.kind     = ROW_REG;
        row.req.func = FUNC_WRITE;
        row.req.addr = '0;
        row.req.data = '0;
        row.req.px   = '0;
        row.req.py   = '0;
        row.how      = EXP_PREDICT;
        row.color    = 2'd0;
        row.reg_idx  = idx;
        row.reg_val  = val;
        dir_rows.push_back(row);
    endtask

    // result side: random stalls, mostly short
    initial
    begin
        int left;
        int stall;
        left = 0;
        pix_out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                stall = steady_phase ? 0 : idle_len();
                if (!pix_out_ch.ready)
                begin
                    pix_out_ch.ready = 1'b1;
                    left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 30);
                end
                else if (stall > 0)
                begin
                    pix_out_ch.ready = 1'b0;
                    left = stall;
                end
                else
                    left = $urandom_range(1, 30);
            end
            left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_out_ch.valid && pix_out_ch.ready)
        begin
            got_pix = {pix_out_ch.color_index, pix_out_ch.out_x, pix_out_ch.out_y};
            if (pixel_expq.size() == 0)
                report_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%0d",
                                          got_pix.x, got_pix.y, got_pix.color));
            else
            begin
                want_pix = pixel_expq.pop_front();
                if (got_pix.color !== want_pix.color)
                    report_mismatch($sformatf("color at (%0d,%0d): got %0d want %0d",
                                              want_pix.x, want_pix.y, got_pix.color,
                                              want_pix.color));
                if (got_pix.x !== want_pix.x)
                    report_mismatch($sformatf("out_x: got %0d want %0d", got_pix.x,
                                              want_pix.x));
                if (got_pix.y !== want_pix.y)
                    report_mismatch($sformatf("out_y: got %0d want %0d", got_pix.y,
                                              want_pix.y));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stuck <= 0;
        else if ((pix_in_ch.valid && pix_in_ch.ready) || (pix_out_ch.valid && pix_out_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready))
            stuck <= 0;
        else if (stuck + 1 >= STUCK_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            stuck <= stuck + 1;
    end

    initial
    begin
        pix_req_t          req;
        int                sent;
        int                phase;
        int                n;
        int                r;
        bit                scan;
        int                sx;
        int                sy;
        logic [MEM_AW-1:0] miss_addr;

        err_cnt            = 0;
        steady_phase       = 1'b0;
        bg_on              = 1'b0;
        map_hi             = 1'b0;
        tiles_unsigned     = 1'b0;
        scx                = '0;
        scy                = '0;
        pix_in_ch.valid    = 1'b0;
        pix_in_ch.func     = FUNC_WRITE;
        pix_in_ch.mem_addr = '0;
        pix_in_ch.mem_data = '0;
        pix_in_ch.pixel_x  = '0;
        pix_in_ch.pixel_y  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_BG_ENABLE;
        cfg_ch.data        = '0;
        rst_n              = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        row_pix(FUNC_RENDER, '0, '0, 8'd0, 8'd0, EXP_TYPED, 2'd0);
        row_pix(FUNC_RENDER, '1, '1, 8'd159, 8'd143, EXP_TYPED, 2'd0);
        row_pix(FUNC_RENDER, '0, '0, 8'd160, 8'd0, EXP_NO_RESULT, 2'd0);
        row_pix(FUNC_RENDER, '0, '0, 8'd0, 8'd144, EXP_NO_RESULT, 2'd0);
        row_pix(FUNC_RENDER, '1, '1, 8'd255, 8'd255, EXP_NO_RESULT, 2'd0);
        row_pix(FUNC_WRITE, 13'h1800, 8'h7F, 8'd0, 8'd0, EXP_PREDICT, 2'd0);
        row_pix(FUNC_WRITE, 13'h17F0, 8'h80, 8'd0, 8'd0, EXP_PREDICT, 2'd0);
        row_pix(FUNC_WRITE, 13'h17F1, 8'h01, 8'd0, 8'd0, EXP_PREDICT, 2'd0);
        row_pix(FUNC_WRITE, 13'h07F0, 8'h40, 8'd0, 8'd0, EXP_PREDICT, 2'd0);
        row_pix(FUNC_WRITE, 13'h07F1, 8'hC0, 8'd0, 8'd0, EXP_PREDICT, 2'd0);
        row_reg(CFG_BG_ENABLE, 8'h01);
        row_pix(FUNC_RENDER, '0, '0, 8'd0, 8'd0, EXP_PREDICT, 2'd0);
        row_pix(FUNC_RENDER, '0, '0, 8'd7, 8'd0, EXP_PREDICT, 2'd0);
        row_reg(CFG_DATA_SELECT, 8'h01);
        row_pix(FUNC_RENDER, '0, '0, 8'd1, 8'd0, EXP_PREDICT, 2'd0);
        row_pix(FUNC_WRITE, 13'h1C00, 8'h80, 8'd0, 8'd0, EXP_PREDICT, 2'd0);
        row_reg(CFG_MAP_SELECT, 8'h01);
        row_pix(FUNC_RENDER, '0, '0, 8'd0, 8'd0, EXP_PREDICT, 2'd0);
        row_reg(CFG_SCROLL_X, 8'hFF);
        row_reg(CFG_SCROLL_Y, 8'hFF);
        row_pix(FUNC_RENDER, '0, '0, 8'd159, 8'd143, EXP_PREDICT, 2'd0);
        row_pix(FUNC_RENDER, '0, '0, 8'd0, 8'd0, EXP_PREDICT, 2'd0);
        row_pix(FUNC_WRITE, 13'h1FFF, 8'hFF, 8'd0, 8'd0, EXP_PREDICT, 2'd0);
        row_pix(FUNC_WRITE, 13'h0000, 8'h00, 8'd0, 8'd0, EXP_PREDICT, 2'd0);
        row_reg(CFG_BG_ENABLE, 8'h00);
        row_pix(FUNC_RENDER, '0, '0, 8'd80, 8'd72, EXP_TYPED, 2'd0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            else
            begin
                if (dir_rows[i].req.func == FUNC_RENDER)
                    prime_render(dir_rows[i].req.px, dir_rows[i].req.py);
                send_pixel(dir_rows[i].req, dir_rows[i].how, dir_rows[i].color);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS)
        begin
            write_reg(CFG_BG_ENABLE, pick_reg_val(CFG_BG_ENABLE));
            write_reg(CFG_MAP_SELECT, pick_reg_val(CFG_MAP_SELECT));
            write_reg(CFG_DATA_SELECT, pick_reg_val(CFG_DATA_SELECT));
            write_reg(CFG_SCROLL_X, pick_reg_val(CFG_SCROLL_X));
            write_reg(CFG_SCROLL_Y, pick_reg_val(CFG_SCROLL_Y));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(CFG_SCROLL_Y + 1, 2**CFG_INDEX_W - 1)),
                          CFG_DATA_W'($urandom));
            steady_phase = ($urandom_range(0, 4) == 0);
            n = $urandom_range(60, 220);
            if (n > RAND_ITEMS - sent)
                n = RAND_ITEMS - sent;
            scan = ($urandom_range(0, 3) == 0);
            sx   = $urandom_range(0, 159);
            sy   = $urandom_range(0, 143);
            for (int i = 0; i < n; i++)
            begin
                if (i == n / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
                    pause_until_drained();
                r = $urandom_range(0, 99);
                req.addr = MEM_AW'($urandom);
                req.data = 8'($urandom);
                req.px   = 8'($urandom);
                req.py   = 8'($urandom);
                if (r < 25)
                    req.func = FUNC_WRITE;
                else
                begin
                    req.func = FUNC_RENDER;
                    if (r >= 33 && scan)
                    begin
                        req.px = 8'(sx);
                        req.py = 8'(sy);
                        sx = (sx + 1) % 160;
                        if (sx == 0)
                            sy = (sy + 1) % 144;
                    end
                    else if (r >= 33)
                    begin
                        req.px = 8'($urandom_range(0, 159));
                        req.py = 8'($urandom_range(0, 143));
                    end
                    // load a byte the render still needs instead
                    if (find_unwritten(req.px, req.py, miss_addr))
                    begin
                        req.func = FUNC_WRITE;
                        req.addr = miss_addr;
                    end
                end
                send_pixel(req, EXP_PREDICT, 2'd0);
            end
            steady_phase = 1'b0;
            sent += n;
            phase++;
        end

        pause_until_drained();
        repeat (SETTLE * 2) @(negedge clk);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
design/tmbf_pkg.sv
design/tmbf_pix_in_if.sv
design/tmbf_pix_out_if.sv
design/tmbf_cfg_if.sv
design/tmbf_front.sv
design/tmbf_queue.sv
design/tmbf_back.sv
design/tile_map_background_fetch_unit.sv
tb/tile_map_background_fetch_unit_tb.sv
